>>> rtl/agema_pkg.sv
// Package for the ADC range gate / EMA smoother: widths, fixed-point constants,
// register indexes and the Celsius conversion helper.
// No dependencies; every rtl file imports this package.
package agema_pkg;

  localparam int RAW_BITS  = 12;
  localparam int FRAC_BITS = 16;
  localparam int OUT_W     = 25;

  // Gain is unsigned Q(1.FRAC_BITS); volts stay below 2.0, so the quotient
  // also needs FRAC_BITS+1 bits.
  localparam int GAIN_W = FRAC_BITS + 1;
  localparam int Q_W    = FRAC_BITS + 1;

  // Volts = floor(raw * 18 * 2^FRAC_BITS / (10 * (2^RAW_BITS - 1))).
  localparam int RAW18_W = RAW_BITS + 5;
  localparam int NUM_W   = RAW18_W + FRAC_BITS;
  localparam int DEN_W   = RAW_BITS + 4;
  localparam logic [DEN_W-1:0] VOLT_DEN = DEN_W'(10 * ((1 << RAW_BITS) - 1));

  localparam logic [GAIN_W-1:0] ONE_Q = GAIN_W'(1 << FRAC_BITS);
  localparam logic signed [OUT_W-1:0] CELSIUS_OFS = OUT_W'(50 * (1 << FRAC_BITS));

  // Serial step counts.
  localparam int DIV_CNT_W = $clog2(Q_W);
  localparam int MUL_CNT_W = $clog2(GAIN_W);
  localparam int DIFF_W    = OUT_W + 1;
  localparam int HI_W      = DIFF_W + 1;
  localparam int SCALED_W  = HI_W + 1;

  // Configuration port.
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = GAIN_W;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_LOW_LIMIT  = 2'd0,
    REG_HIGH_LIMIT = 2'd1,
    REG_GAIN       = 2'd2,
    REG_TEMP_MODE  = 2'd3
  } agema_reg_t;

  // 100 * volts - 50.0, built from shifts: 100 = 64 + 32 + 4.
  function automatic logic signed [OUT_W-1:0] to_celsius(input logic [Q_W-1:0] volts);
    logic signed [OUT_W-1:0] v;
    v = OUT_W'(volts);
    return (v <<< 6) + (v <<< 5) + (v <<< 2) - CELSIUS_OFS;
  endfunction

endpackage

>>> rtl/agema_div.sv
// Bit-serial restoring divider: raw count to volts, one quotient bit a cycle.
// Depends on agema_pkg.
module agema_div
  import agema_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [RAW_BITS-1:0] raw,
  output logic                done,
  output logic [Q_W-1:0]      volts
);

  logic [NUM_W-1:0]     num;
  logic [DEN_W-1:0]     rem;
  logic [Q_W-1:0]       qsh;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic [DEN_W:0]       partial;
  logic [DEN_W:0]       trial;

  assign num     = {RAW18_W'({raw, 4'b0000}) + RAW18_W'({raw, 1'b0}), FRAC_BITS'(0)};
  assign partial = {rem, qsh[Q_W-1]};
  assign trial   = partial - {1'b0, VOLT_DEN};
  assign volts   = qsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        // Upper bits are below the divisor since the quotient fits Q_W bits.
        rem  <= num[NUM_W-1:Q_W];
        qsh  <= num[Q_W-1:0];
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        // Shift in the next numerator bit, shift out one quotient bit.
        if (!trial[DEN_W]) begin
          rem <= trial[DEN_W-1:0];
          qsh <= {qsh[Q_W-2:0], 1'b1};
        end else begin
          rem <= partial[DEN_W-1:0];
          qsh <= {qsh[Q_W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(Q_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/agema_mul.sv
// Bit-serial shift-add multiplier: gain * (sample - average), floor-scaled
// by 2^FRAC_BITS. One gain bit per cycle. Depends on agema_pkg.
module agema_mul
  import agema_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [GAIN_W-1:0]          gain,
  input  logic signed [DIFF_W-1:0]   diff,
  output logic                       done,
  output logic signed [SCALED_W-1:0] scaled
);

  logic signed [DIFF_W-1:0] d;
  logic signed [HI_W-1:0]   hi;
  logic [GAIN_W-1:0]        lo;
  logic [MUL_CNT_W-1:0]     cnt;
  logic                     busy;
  logic signed [HI_W-1:0]   addend;
  logic signed [HI_W-1:0]   sum;

  assign addend = lo[0] ? HI_W'(d) : '0;
  assign sum    = hi + addend;
  // Low product bits collect in lo; keep bit FRAC_BITS for the floor shift.
  assign scaled = {hi, lo[GAIN_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        d    <= diff;
        hi   <= '0;
        lo   <= gain;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        hi  <= sum >>> 1;
        lo  <= {sum[0], lo[GAIN_W-1:1]};
        cnt <= cnt + 1'b1;
        if (cnt == MUL_CNT_W'(GAIN_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/adc_range_gate_ema_smoother_top.sv
// ADC range gate with EMA smoother, top level. Uses agema_pkg, agema_div, agema_mul.
// Sequence for a valid count: ST_DIV runs the divider steps, then sees done and converts;
//   ST_CONV checks the seed, ST_MUL runs the multiplier steps and sees done, ST_DONE loads
//   the output register; the first sample skips the multiplier.
// Throughput: one item at a time, plus any wait for the output register; a rejected count
//   is dropped in idle. The bit-serial divider and multiplier loops take most of the time.
//   A held result does not block input.
// Reset (rst, synchronous): registers to their defaults, average unseeded, no result.
module adc_range_gate_ema_smoother_top
  import agema_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [15:0]           s_tdata,   // [11:0] raw_count, rest zero
  input  logic                  s_tuser,   // [0] read_ok
  // Result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [55:0]           m_tdata,   // [24:0] sample_value, [49:25] smoothed_value
  output logic                  m_tuser,   // [0] watchdog_kick
  // Configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_CONV,
    ST_MUL,
    ST_DONE
  } state_t;

  state_t state;

  // Configuration registers
  logic [RAW_BITS-1:0] low_limit;
  logic [RAW_BITS-1:0] high_limit;
  logic [GAIN_W-1:0]   smoothing_gain;
  logic                temperature_mode;

  // Filter state and working registers
  logic                    seeded;
  logic signed [OUT_W-1:0] average;
  logic signed [OUT_W-1:0] sample;
  logic signed [OUT_W-1:0] avg_new;

  logic signed [OUT_W-1:0] sample_out;
  logic signed [OUT_W-1:0] smoothed_out;

  // Datapath hookup
  logic [RAW_BITS-1:0]       raw_count;
  logic                      in_xfer;
  logic                      in_pass;
  logic                      div_done;
  logic [Q_W-1:0]            volts;
  logic                      mul_start;
  logic                      mul_done;
  logic [GAIN_W-1:0]         gain_sat;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [SCALED_W-1:0] scaled;
  logic                      out_free;

  assign raw_count = s_tdata[RAW_BITS-1:0];
  assign s_tready  = (state == ST_IDLE);
  assign in_xfer   = s_tvalid && s_tready;
  // Gate: read must succeed and the count must sit in the inclusive window.
  assign in_pass   = in_xfer && s_tuser && (raw_count >= low_limit) &&
                     (raw_count <= high_limit);

  // Saturate gain at one; a larger weight would overshoot the sample.
  assign gain_sat  = (smoothing_gain > ONE_Q) ? ONE_Q : smoothing_gain;
  assign diff      = DIFF_W'(sample) - DIFF_W'(average);
  assign mul_start = (state == ST_CONV) && seeded;

  // Output register is free once empty or its transfer completes this cycle.
  assign out_free  = !m_tvalid || m_tready;

  assign m_tdata   = {6'b0, smoothed_out, sample_out};
  assign m_tuser   = 1'b1;

  agema_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (in_pass),
    .raw   (raw_count),
    .done  (div_done),
    .volts (volts)
  );

  agema_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .gain   (gain_sat),
    .diff   (diff),
    .done   (mul_done),
    .scaled (scaled)
  );

  // Configuration writes; the host must write only while no item is in flight; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      low_limit        <= '0;
      high_limit       <= RAW_BITS'((1 << RAW_BITS) - 1);
      smoothing_gain   <= GAIN_W'(1 << (FRAC_BITS - 2));
      temperature_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (agema_reg_t'(cfg_addr))
        REG_LOW_LIMIT:  low_limit        <= cfg_wdata[RAW_BITS-1:0];
        REG_HIGH_LIMIT: high_limit       <= cfg_wdata[RAW_BITS-1:0];
        REG_GAIN:       smoothing_gain   <= cfg_wdata[GAIN_W-1:0];
        REG_TEMP_MODE:  temperature_mode <= cfg_wdata[0];
        default:        ;
      endcase
    end
  end

  // Sequencer: gate, divide, convert, multiply, hand off to output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      seeded   <= 1'b0;
      average  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // Retire a completed transfer unless a new result loads this cycle.
      if (m_tready && (state != ST_DONE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          // Drop failed or out-of-window reads without touching state.
          if (in_pass) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            sample <= temperature_mode ? to_celsius(volts) : OUT_W'(volts);
            state  <= ST_CONV;
          end
        end
        ST_CONV: begin
          // First valid sample seeds the average directly.
          if (seeded) begin
            state <= ST_MUL;
          end else begin
            avg_new <= sample;
            state   <= ST_DONE;
          end
        end
        ST_MUL: begin
          // avg + floor(g * (s - avg) / 2^FRAC_BITS) equals the weighted mix.
          if (mul_done) begin
            avg_new <= average + scaled[OUT_W-1:0];
            state   <= ST_DONE;
          end
        end
        ST_DONE: begin
          // Hold here until the output register can take the result.
          if (out_free) begin
            m_tvalid     <= 1'b1;
            sample_out   <= sample;
            smoothed_out <= avg_new;
            average      <= avg_new;
            seeded       <= 1'b1;
            state        <= ST_IDLE;
          end else begin
            m_tvalid     <= 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> verif/tb.sv
// Testbench for adc_range_gate_ema_smoother_top: range gate, volt/Celsius conversion
// and moving-average update, checked against a predictor kept inside this file.
// Depends on rtl/agema_pkg.sv and the RTL of the block; no files, no arguments.
`timescale 1ns / 100ps

module tb;
  import agema_pkg::*;

  // Run limits: the slowest legal run is roughly 2100 polls plus the long hold-offs;
  // the limit leaves a wide margin over that.
  localparam int  CYCLE_LIMIT = 1_000_000;
  // Cycles to wait after the last result before touching the registers: covers
  // a poll still in the serial divider/multiplier.
  localparam int  SETTLE      = 60;
  localparam int  PHASE_POLLS = 250;

  localparam longint ONE_FX     = longint'(1) << FRAC_BITS;
  localparam longint FULL_SCALE = (longint'(1) << RAW_BITS) - 1;

  // One result transfer: fields from the lowest bits of the result stream.
  typedef struct packed {
    logic [OUT_W-1:0] smp_val;
    logic [OUT_W-1:0] avg_val;
    logic             kick;
  } reading_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [15:0]           s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [55:0]           m_tdata;
  logic                  m_tuser;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  adc_range_gate_ema_smoother_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  // Predictor copy of the registers and of the filter state, reset values.
  logic [RAW_BITS-1:0] win_lo    = '0;
  logic [RAW_BITS-1:0] win_hi    = '1;
  logic [GAIN_W-1:0]   ema_gain  = GAIN_W'(16384);
  logic                celsius_on = 1'b0;
  logic                avg_seeded = 1'b0;
  longint              avg_fx     = 0;

  reading_t pending_readings[$];
  reading_t oldest;
  int       mismatches = 0;
  longint   cycle_cnt  = 0;

  // Receiver control: pattern selector and a hold-off request picked up by the
  // receiver process, which then counts the hold-off itself.
  bit rx_bursty  = 1'b0;
  int hold_req   = 0;
  int hold_cnt   = 0;
  int rx_run     = 0;
  bit rx_stalled = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: either always ready or alternating ready/stall runs of random
  // length; a hold-off request overrides both for its full count.
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt = hold_cnt - 1;
      m_tready <= 1'b0;
    end else if (!rx_bursty) begin
      m_tready <= 1'b1;
    end else begin
      if (rx_run == 0) begin
        rx_stalled = !rx_stalled;
        rx_run = rx_stalled ? $urandom_range(1, 12) : $urandom_range(1, 20);
      end
      rx_run = rx_run - 1;
      m_tready <= !rx_stalled;
    end
  end

  // Result checker: every result transfer is compared with the oldest pending
  // reading. Values sampled here are the ones present before the edge.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_readings.size() == 0) begin
        $display("%0t: unexpected result, expected none, got sample %0d avg %0d",
                 $time, $signed(m_tdata[24:0]), $signed(m_tdata[49:25]));
        mismatches++;
      end else begin
        oldest = pending_readings.pop_front();
        if (m_tdata[24:0] !== oldest.smp_val) begin
          $display("%0t: sample_value expected %0d, got %0d", $time,
                   $signed(oldest.smp_val), $signed(m_tdata[24:0]));
          mismatches++;
        end
        if (m_tdata[49:25] !== oldest.avg_val) begin
          $display("%0t: smoothed_value expected %0d, got %0d", $time,
                   $signed(oldest.avg_val), $signed(m_tdata[49:25]));
          mismatches++;
        end
        if (m_tuser !== oldest.kick) begin
          $display("%0t: watchdog_kick expected %0b, got %0b", $time,
                   oldest.kick, m_tuser);
          mismatches++;
        end
      end
    end
  end

  // Gate, convert and smooth one poll; returns 1 and the reading when the poll
  // passes the gate, and advances the average.
  function automatic bit gate_and_smooth(input logic [RAW_BITS-1:0] raw, input logic ok,
                                         output reading_t r);
    longint smp;
    longint g;
    longint acc;
    r = '0;
    if (!ok || raw < win_lo || raw > win_hi) return 1'b0;
    // Volts truncated first, Celsius built from the truncated volts.
    smp = (longint'(raw) * 18 * ONE_FX) / (10 * FULL_SCALE);
    if (celsius_on) smp = 100 * smp - 50 * ONE_FX;
    if (!avg_seeded) begin
      avg_fx = smp;
      avg_seeded = 1'b1;
    end else begin
      // Gain above one saturates; the shift floors toward minus infinity.
      g = (longint'(ema_gain) > ONE_FX) ? ONE_FX : longint'(ema_gain);
      acc = g * smp + (ONE_FX - g) * avg_fx;
      avg_fx = acc >>> FRAC_BITS;
    end
    r.smp_val = smp[OUT_W-1:0];
    r.avg_val = avg_fx[OUT_W-1:0];
    r.kick    = 1'b1;
    return 1'b1;
  endfunction

  // Offer one poll and hold it until the transfer. Valid stays high on return,
  // so the caller either offers the next poll or idles in the same step.
  task automatic send_poll(input logic [RAW_BITS-1:0] raw, input logic ok,
                           output bit produced);
    reading_t r;
    s_tvalid <= 1'b1;
    s_tdata  <= 16'(raw);
    s_tuser  <= ok;
    do @(posedge clk); while (!s_tready);
    produced = gate_and_smooth(raw, ok, r);
    if (produced) pending_readings.push_back(r);
  endtask

  task automatic idle_input(input int cycles);
    if (cycles > 0) begin
      s_tvalid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Stop offering, wait for every pending reading, then let the block settle.
  task automatic drain;
    s_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Drive one register write; cfg_we is left high for a following write.
  task automatic write_reg(input agema_reg_t idx, input logic [CFG_DATA_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    case (idx)
      REG_LOW_LIMIT:  win_lo     = v[RAW_BITS-1:0];
      REG_HIGH_LIMIT: win_hi     = v[RAW_BITS-1:0];
      REG_GAIN:       ema_gain   = v;
      REG_TEMP_MODE:  celsius_on = v[0];
      default: ;
    endcase
  endtask

  // Write all four registers; call only with the block idle.
  task automatic write_config(input logic [CFG_DATA_W-1:0] lo, input logic [CFG_DATA_W-1:0] hi,
                              input logic [CFG_DATA_W-1:0] gain,
                              input logic [CFG_DATA_W-1:0] mode);
    write_reg(REG_LOW_LIMIT, lo);
    write_reg(REG_HIGH_LIMIT, hi);
    write_reg(REG_GAIN, gain);
    write_reg(REG_TEMP_MODE, mode);
    cfg_we <= 1'b0;
  endtask

  // Count extremes and alternating bit patterns under reset defaults; the
  // first poll seeds the average, a failed read is dropped.
  task automatic test_count_extremes;
    bit p;
    send_poll(12'd0, 1'b1, p);
    send_poll(12'd4095, 1'b1, p);
    send_poll(12'hAAA, 1'b1, p);
    send_poll(12'h555, 1'b1, p);
    send_poll(12'd100, 1'b0, p);
    send_poll(12'd1, 1'b1, p);
    send_poll(12'd4094, 1'b1, p);
    drain();
  endtask

  // Inclusive window edges, a failed read inside it, then an inverted window
  // that must drop everything.
  task automatic test_window_gate;
    bit p;
    write_config(17'd100, 17'd200, 17'd16384, 17'd0);
    send_poll(12'd99, 1'b1, p);
    send_poll(12'd100, 1'b1, p);
    send_poll(12'd200, 1'b1, p);
    send_poll(12'd201, 1'b1, p);
    send_poll(12'd150, 1'b0, p);
    drain();
    write_config(17'd300, 17'd200, 17'd16384, 17'd0);
    send_poll(12'd250, 1'b1, p);
    send_poll(12'd300, 1'b1, p);
    send_poll(12'd200, 1'b1, p);
    drain();
  endtask

  // Gain zero holds the average, one follows the sample, above one saturates; then a one-LSB gain.
  task automatic test_gain_edges;
    bit p;
    write_config(17'd0, 17'd4095, 17'd0, 17'd0);
    send_poll(12'd2000, 1'b1, p);
    send_poll(12'd3000, 1'b1, p);
    drain();
    write_config(17'd0, 17'd4095, 17'd65536, 17'd0);
    send_poll(12'd1000, 1'b1, p);
    drain();
    write_config(17'd0, 17'd4095, 17'h1FFFF, 17'd0);
    send_poll(12'd3500, 1'b1, p);
    drain();
    write_config(17'd0, 17'd4095, 17'd1, 17'd0);
    send_poll(12'd2222, 1'b1, p);
    drain();
  endtask

  // Celsius at both ends of the scale; switching modes does not reseed.
  task automatic test_temperature_mode;
    bit p;
    write_config(17'd0, 17'd4095, 17'd32768, 17'd1);
    send_poll(12'd0, 1'b1, p);
    send_poll(12'd4095, 1'b1, p);
    send_poll(12'd2048, 1'b1, p);
    drain();
    write_config(17'd0, 17'd4095, 17'd32768, 17'd0);
    send_poll(12'd1234, 1'b1, p);
    drain();
  endtask

  // Hold the receiver off for a long stretch while polls keep coming, so the
  // block fills and stalls its input; then pause until all results are in.
  task automatic test_backpressure;
    bit p;
    write_config(17'd0, 17'd4095, 17'd20000, 17'd0);
    hold_req = 600;
    rx_bursty = 1'b0;
    repeat (30) send_poll(12'($urandom_range(0, 4095)), 1'b1, p);
    drain();
  endtask

  // Pick a register setting, extremes included; upper write-data bits beyond
  // a register's width carry junk now and then.
  task automatic random_config;
    logic [CFG_DATA_W-1:0] lo;
    logic [CFG_DATA_W-1:0] hi;
    logic [CFG_DATA_W-1:0] gain;
    logic [CFG_DATA_W-1:0] mode;
    logic [CFG_DATA_W-1:0] tmp;
    case ($urandom_range(0, 9))
      0: begin lo = 0;    hi = 4095; end
      1: begin lo = 4095; hi = 4095; end
      2: begin lo = 0;    hi = 0;    end
      3: begin
        lo = CFG_DATA_W'($urandom_range(1000, 4095));
        hi = CFG_DATA_W'($urandom_range(0, 999));
      end
      default: begin
        lo = CFG_DATA_W'($urandom_range(0, 4095));
        hi = CFG_DATA_W'($urandom_range(0, 4095));
        if (lo > hi) begin tmp = lo; lo = hi; hi = tmp; end
      end
    endcase
    case ($urandom_range(0, 6))
      0: gain = 0;
      1: gain = 65536;
      2: gain = CFG_DATA_W'($urandom_range(65537, 131071));
      3: gain = CFG_DATA_W'($urandom_range(1, 255));
      default: gain = CFG_DATA_W'($urandom_range(0, 65536));
    endcase
    mode = CFG_DATA_W'($urandom_range(0, 1));
    if ($urandom_range(0, 3) == 0) begin
      lo   = lo | (CFG_DATA_W'($urandom_range(0, 31)) << RAW_BITS);
      hi   = hi | (CFG_DATA_W'($urandom_range(0, 31)) << RAW_BITS);
      mode = mode | (CFG_DATA_W'($urandom_range(0, 65535)) << 1);
    end
    write_config(lo, hi, gain, mode);
  endtask

  // One phase of random polls: mostly good reads inside the window, some
  // failed reads and out-of-window counts, sender bursts and receiver stalls.
  task automatic run_poll_phase(input int target, input bit tx_bursty);
    int sent;
    int burst_left;
    logic [RAW_BITS-1:0] raw;
    logic ok;
    bit p;
    sent = 0;
    burst_left = 0;
    while (sent < target) begin
      if (tx_bursty && burst_left == 0) begin
        idle_input(($urandom_range(0, 3) == 0) ? $urandom_range(10, 45) : $urandom_range(0, 5));
        burst_left = $urandom_range(1, 16);
      end
      if (win_lo <= win_hi && $urandom_range(0, 9) < 7)
        raw = RAW_BITS'($urandom_range(win_lo, win_hi));
      else
        raw = RAW_BITS'($urandom_range(0, 4095));
      ok = ($urandom_range(0, 9) != 0);
      send_poll(raw, ok, p);
      if (tx_bursty) burst_left--;
      sent++;
    end
    drain();
  endtask

  task automatic test_random_traffic;
    for (int ph = 0; ph < 8; ph++) begin
      random_config();
      // Phase 2 runs both sides with no idling at all.
      rx_bursty = (ph == 2) ? 1'b0 : 1'($urandom_range(0, 3) != 0);
      run_poll_phase(PHASE_POLLS, (ph == 2) ? 1'b0 : 1'b1);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    rx_bursty = 1'b1;
    test_count_extremes();
    test_window_gate();
    test_gain_edges();
    test_temperature_mode();
    test_backpressure();
    test_random_traffic();
    drain();
    if (mismatches == 0 && pending_readings.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
